// ===== src/lsg_pkg.sv =====
package lsg_pkg;

  // field and register widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned AMT_W      = 7;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // fixed-point formats
  localparam int unsigned FRAC_W     = 16;           // q1.16 fraction bits
  localparam int unsigned Q16_W      = FRAC_W + 1;   // q1.16 values up to one
  localparam int unsigned SINE_W     = 16;           // signed q1.15 sine
  localparam int unsigned SINE_MAG_W = SINE_W - 1;   // quarter-wave magnitude
  localparam int unsigned USUM_W     = SINE_W + 3;   // 4*x + offset before clamp
  localparam int unsigned GMUL_AW    = Q16_W + 2;    // signed multiplicand of gain unit
  localparam int unsigned QUAD_SHIFT = PHASE_W - 2;  // phase bits within a quadrant

  // defaults of the top-level parameters
  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned SINE_DEPTH_DEF  = 1024;

  typedef logic        [Q16_W-1:0]    q16_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [PHASE_W-1:0]  phase_t;
  typedef logic        [AMT_W-1:0]    amt_t;
  typedef logic        [RATE_W-1:0]   rate_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } lsg_in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } lsg_out_t;

  // register reset values
  localparam amt_t  AMT_RESET  = 7'd50;
  localparam rate_t RATE_RESET = 8'd80;
  localparam int unsigned AMT_FULL = 100;

  // shaping constants
  localparam logic signed [USUM_W-1:0] U_OFFSET     = 19'sd52429;  // 0.8 in q0.16
  localparam q16_t                     ONE_Q16      = 17'd65536;
  localparam logic        [Q16_W:0]    SMOOTH_THREE = 18'd196608;  // 3.0 in q2.16
  localparam logic [SINE_MAG_W-1:0]    SINE_PEAK    = 15'd32767;
  localparam int                       ROUND_HALF   = 32768;

  // quarter-wave table generation, q2.30
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_SCALE  = 64'd32767;
  localparam longint unsigned Q30_HALF    = 64'd536870912;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                 64'd42, 64'd20, 64'd6};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMOUNT = 1'b0,
    CFG_RATE   = 1'b1
  } lsg_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_SQUARE,
    ST_SMOOTH,
    ST_DEPTH,
    ST_SCALE,
    ST_HOLD
  } lsg_state_e;

  // taylor series of degree 13, horner form, angle in q2.30
  function automatic logic [SINE_MAG_W-1:0] sine_q15(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
    end
    s = (x * t) >> 30;
    v = (s * SINE_SCALE + Q30_HALF) >> 30;
    if (v > SINE_SCALE) begin
      v = SINE_SCALE;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

// ===== src/lsg_stream_if.sv =====
interface lsg_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/lsg_sine_rom.sv =====
module lsg_sine_rom #(
  parameter int unsigned DEPTH = lsg_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rd_en_i,
  input  lsg_pkg::phase_t                   phase_i,
  output logic signed [lsg_pkg::SINE_W-1:0] sine_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned QS = lsg_pkg::QUAD_SHIFT;
  localparam int unsigned SW = QS + DW;
  localparam int unsigned MW = lsg_pkg::SINE_MAG_W;

  logic [MW-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam longint unsigned X = lsg_pkg::HALF_PI_Q30 * i / DEPTH;
    assign rom[i] = lsg_pkg::sine_q15(X);
  end

  logic [SW-1:0] scaled;
  logic [AW-1:0] pos;
  logic [DW-1:0] idx;
  logic          peak;
  logic [AW-1:0] addr;

  always_comb begin
    scaled = SW'(phase_i[QS-1:0]) * SW'(DEPTH);
    pos    = scaled[QS +: AW];
    // odd quadrants run the table backwards
    idx    = phase_i[QS] ? (DW'(DEPTH) - DW'(pos)) : DW'(pos);
    peak   = phase_i[QS] && (pos == '0);
    addr   = peak ? '0 : idx[AW-1:0];
  end

  logic [MW-1:0] mag_q;
  logic          neg_q;
  logic          peak_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q  <= rom[addr];
      neg_q  <= phase_i[QS+1];
      peak_q <= peak;
    end
  end

  logic [lsg_pkg::SINE_W-1:0] mag;

  always_comb begin
    mag    = {1'b0, (peak_q ? lsg_pkg::SINE_PEAK : mag_q)};
    sine_o = neg_q ? -$signed(mag) : $signed(mag);
  end

endmodule

// ===== src/lsg_mul.sv =====
module lsg_mul #(
  parameter int unsigned AW = lsg_pkg::GMUL_AW,
  parameter int unsigned BW = lsg_pkg::Q16_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic        [BW-1:0] b_i,
  output logic                 done_o,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = (BW > 1) ? $clog2(BW) : 1;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;

  logic signed [AW-1:0] a_q;
  logic        [BW-1:0] b_q;
  logic signed [AW:0]   hi_q;
  logic        [BW-1:0] lo_q;

  logic signed [AW:0] sum;

  // lsb first: add the multiplicand on a set bit, shift one bit into the low half
  always_comb begin
    sum = hi_q + (b_q[0] ? {a_q[AW-1], a_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      b_q  <= b_q >> 1;
      hi_q <= sum >>> 1;
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({hi_q[AW-1:0], lo_q});

endmodule

// ===== src/lfo_stutter_gate.sv =====
// lfo stutter gate: a tremolo gate for one stereo sample pair per word. A
// 32-bit phase accumulator steps by rate_dhz/10 Hz at SAMPLE_RATE and picks a
// sine from a quarter-wave rom (q1.15, truncated to an entry, taken from the phase
// before it advances). The sine is mapped to u = 2*x + 0.8 clamped to 0..1,
// shaped by smoothstep, and blended into a q1.16 gain
// (1 - amount) + amount*smoothstep that scales both channels with rounding.
// An amount register above 100 acts as 100; amount 0 passes audio unchanged.
// A new word is taken only once the last one has reached the output register. After
// the input word is taken the rom is read, the shape state registers u, and then
// four rounds of bit-serial 17-step multiplication run back to back: u*u, u^2*(3-2u)
// and amount*s on the shared gain multiplier, then the gain on the two sample
// lanes. The result sits in an output register, so the next input word is
// taken while it waits. Configuration writes are taken at any time but are
// meant for an idle block; written while idle, they apply from the next word on.
module lfo_stutter_gate #(
  parameter int unsigned SAMPLE_RATE      = lsg_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = lsg_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  lsg_stream_if.sink                        in_i,
  lsg_stream_if.source                      out_o
);

  localparam int unsigned QW  = lsg_pkg::Q16_W;
  localparam int unsigned FW  = lsg_pkg::FRAC_W;
  localparam int unsigned GAW = lsg_pkg::GMUL_AW;
  localparam int unsigned GPW = GAW + QW;                  // gain unit product
  localparam int unsigned SPW = lsg_pkg::SAMPLE_W + QW;    // sample lane product
  localparam int unsigned UW  = lsg_pkg::USUM_W;

  // ---------------------------------------------------------------------------
  // constant tables: phase step per rate code, blend depth per amount code
  // ---------------------------------------------------------------------------
  lsg_pkg::phase_t step_tab [2**lsg_pkg::RATE_W];
  lsg_pkg::q16_t   amt_tab  [2**lsg_pkg::AMT_W];

  for (genvar r = 0; r < 2**lsg_pkg::RATE_W; r++) begin : g_step
    // round(rate * 2^32 / (10 * fs))
    localparam longint unsigned STEP =
      ((longint'(r) << 32) + 5 * longint'(SAMPLE_RATE)) / (10 * longint'(SAMPLE_RATE));
    assign step_tab[r] = STEP[lsg_pkg::PHASE_W-1:0];
  end

  for (genvar i = 0; i < 2**lsg_pkg::AMT_W; i++) begin : g_amt
    // saturate at full depth, then round(pct * 65536 / 100)
    localparam int unsigned PCT = (i > lsg_pkg::AMT_FULL) ? lsg_pkg::AMT_FULL : i;
    localparam int unsigned AMT =
      (PCT * (2**FW) + lsg_pkg::AMT_FULL / 2) / lsg_pkg::AMT_FULL;
    assign amt_tab[i] = lsg_pkg::q16_t'(AMT);
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  lsg_pkg::amt_t   amount_q;
  lsg_pkg::rate_t  rate_q;
  lsg_pkg::phase_t phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= lsg_pkg::AMT_RESET;
      rate_q   <= lsg_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsg_pkg::CFG_AMOUNT: amount_q <= cfg_data_i[lsg_pkg::AMT_W-1:0];
        lsg_pkg::CFG_RATE:   rate_q   <= cfg_data_i[lsg_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer signals
  // ---------------------------------------------------------------------------
  lsg_pkg::lsg_state_e state_q, state_d;

  logic                  in_ready;
  logic                  accept;
  logic                  gmul_start;
  logic signed [GAW-1:0] gmul_a;
  lsg_pkg::q16_t         gmul_b;
  logic                  gmul_done;
  logic signed [GPW-1:0] gmul_prod;
  logic                  smul_start;
  logic                  ldone, rdone;
  logic signed [SPW-1:0] lprod, rprod;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  out_load;

  assign accept   = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------------
  // lfo phase and sine lookup; the sine is valid in the shape state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept) begin
      phase_q <= phase_q + step_tab[rate_q];
    end
  end

  logic signed [lsg_pkg::SINE_W-1:0] sine;

  lsg_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (accept),
    .phase_i (phase_q),
    .sine_o  (sine)
  );

  // ---------------------------------------------------------------------------
  // datapath around the multipliers
  // ---------------------------------------------------------------------------
  lsg_pkg::sample_t left_q, right_q;
  lsg_pkg::q16_t    u_q;

  logic signed [UW-1:0]  u_sum;
  lsg_pkg::q16_t         u_d;
  logic        [QW:0]    w;          // 3 - 2u in q2.16
  logic signed [GPW-1:0] gsum;
  lsg_pkg::q16_t         g_round;    // rounded q1.16 result of the gain unit
  lsg_pkg::q16_t         amt;
  logic        [QW:0]    gain_full;
  lsg_pkg::q16_t         gain;
  logic signed [SPW-1:0] lsum, rsum;

  always_comb begin
    // u = 2*x + 0.8 in q1.16, clamped to 0..1
    u_sum = ($signed({{(UW - lsg_pkg::SINE_W){sine[lsg_pkg::SINE_W-1]}}, sine}) <<< 2)
            + lsg_pkg::U_OFFSET;
    if (u_sum[UW-1]) begin
      u_d = '0;
    end else if (u_sum > $signed(UW'(lsg_pkg::ONE_Q16))) begin
      u_d = lsg_pkg::ONE_Q16;
    end else begin
      u_d = u_sum[QW-1:0];
    end
    w         = lsg_pkg::SMOOTH_THREE - {u_q, 1'b0};
    gsum      = gmul_prod + GPW'(lsg_pkg::ROUND_HALF);
    g_round   = gsum[FW +: QW];
    amt       = amt_tab[amount_q];
    gain_full = {1'b0, lsg_pkg::ONE_Q16} - {1'b0, amt} + {1'b0, g_round};
    gain      = gain_full[QW-1:0];
    // round half up, then floor by the arithmetic shift
    lsum      = lprod + SPW'(lsg_pkg::ROUND_HALF);
    rsum      = rprod + SPW'(lsg_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q  <= in_i.data.left_in;
      right_q <= in_i.data.right_in;
    end
    if (state_q == lsg_pkg::ST_SHAPE) begin
      u_q <= u_d;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: one word at a time through the shared gain multiplier, then
  // both sample lanes together
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    gmul_start = 1'b0;
    gmul_a     = '0;
    gmul_b     = '0;
    smul_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      lsg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = lsg_pkg::ST_SHAPE;
        end
      end
      lsg_pkg::ST_SHAPE: begin
        // u * u
        gmul_start = 1'b1;
        gmul_a     = $signed({2'b00, u_d});
        gmul_b     = u_d;
        state_d    = lsg_pkg::ST_SQUARE;
      end
      lsg_pkg::ST_SQUARE: begin
        // u^2 * (3 - 2u)
        if (gmul_done) begin
          gmul_start = 1'b1;
          gmul_a     = $signed({1'b0, w});
          gmul_b     = g_round;
          state_d    = lsg_pkg::ST_SMOOTH;
        end
      end
      lsg_pkg::ST_SMOOTH: begin
        // amount * smoothstep
        if (gmul_done) begin
          gmul_start = 1'b1;
          gmul_a     = $signed({2'b00, amt});
          gmul_b     = g_round;
          state_d    = lsg_pkg::ST_DEPTH;
        end
      end
      lsg_pkg::ST_DEPTH: begin
        if (gmul_done) begin
          smul_start = 1'b1;
          state_d    = lsg_pkg::ST_SCALE;
        end
      end
      lsg_pkg::ST_SCALE: begin
        if (ldone && rdone) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = lsg_pkg::ST_IDLE;
          end else begin
            state_d  = lsg_pkg::ST_HOLD;
          end
        end
      end
      lsg_pkg::ST_HOLD: begin
        // lane products stay put until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = lsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsg_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // multipliers
  // ---------------------------------------------------------------------------
  lsg_mul #(
    .AW (GAW),
    .BW (QW)
  ) u_gain_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gmul_start),
    .a_i     (gmul_a),
    .b_i     (gmul_b),
    .done_o  (gmul_done),
    .prod_o  (gmul_prod)
  );

  lsg_mul #(
    .AW (lsg_pkg::SAMPLE_W),
    .BW (QW)
  ) u_left_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smul_start),
    .a_i     (left_q),
    .b_i     (gain),
    .done_o  (ldone),
    .prod_o  (lprod)
  );

  lsg_mul #(
    .AW (lsg_pkg::SAMPLE_W),
    .BW (QW)
  ) u_right_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smul_start),
    .a_i     (right_q),
    .b_i     (gain),
    .done_o  (rdone),
    .prod_o  (rprod)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  lsg_pkg::lsg_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.left_out  <= lsum[FW +: lsg_pkg::SAMPLE_W];
      out_data_q.right_out <= rsum[FW +: lsg_pkg::SAMPLE_W];
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== verif/tb_lfo_stutter_gate.sv =====
module tb_lfo_stutter_gate;
  import lsg_pkg::*;

  // block parameters as built here
  localparam int AUDIO_RATE = 48000;
  localparam int ROM_DEPTH  = 1024;

  // q2.30 constants for the quarter-wave rom
  localparam longint unsigned Q30_UNIT         = 64'd1073741824;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  // run limits
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 240;
  localparam int SWEEP_WORDS  = 500;  // a bit past a quarter lfo turn at 25.5 hz

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lsg_stream_if #(.word_t(lsg_in_t))  in_if ();
  lsg_stream_if #(.word_t(lsg_out_t)) out_if ();

  lfo_stutter_gate #(
    .SAMPLE_RATE      (AUDIO_RATE),
    .SINE_TABLE_DEPTH (ROM_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // shadow of the block state used for prediction
  logic [SINE_MAG_W-1:0] sine_rom [ROM_DEPTH];
  phase_t lfo_acc;
  amt_t   depth_reg;
  rate_t  rate_reg;

  // predicted gated sample pairs, oldest first
  lsg_out_t gated_q [$];
  int mismatch_count;
  int cycle_count;
  bit calm;  // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a correct run ends long before this
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // quarter-wave sine in q1.15 from a degree-13 taylor series in horner form
  function automatic void build_sine_rom();
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned poly;
    longint unsigned mag;
    longint unsigned val;
    longint unsigned div_n;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      ang  = QUARTER_TURN_Q30 * longint'(i) / longint'(ROM_DEPTH);
      ang2 = (ang * ang) >> 30;
      poly = Q30_UNIT;
      // divisors 12*13, 10*11, ... 2*3
      for (int k = 0; k < 6; k++) begin
        div_n = longint'((12 - 2 * k) * (13 - 2 * k));
        poly  = Q30_UNIT - ((ang2 * poly) >> 30) / div_n;
      end
      mag = (ang * poly) >> 30;
      val = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
      if (val > 64'd32767) begin
        val = 64'd32767;
      end
      sine_rom[i] = val[SINE_MAG_W-1:0];
    end
  endfunction

  // sample times q1.16 gain, rounded half up
  function automatic sample_t apply_gain(sample_t smp, longint gain);
    longint prod;
    prod = (longint'(smp) * gain + 32768) >>> 16;
    return prod[SAMPLE_W-1:0];
  endfunction

  // gain from the current lfo phase, then advance the phase
  task automatic predict_gate(input lsg_in_t w, output lsg_out_t r);
    logic [1:0] quad;
    longint idx;
    longint sine;
    longint step;
    longint u;
    longint u2;
    longint shaped;
    longint amt;
    longint gain;
    quad = lfo_acc[31:30];
    idx  = (longint'(lfo_acc[29:0]) * ROM_DEPTH) >>> 30;
    // odd quadrants run the rom backwards; the index one past the end is the peak
    if (quad[0]) begin
      idx = ROM_DEPTH - idx;
    end
    sine = (idx >= ROM_DEPTH) ? 32767 : longint'(sine_rom[idx]);
    if (quad[1]) begin
      sine = -sine;
    end
    step = ((longint'(rate_reg) << 32) + 5 * AUDIO_RATE) / (10 * AUDIO_RATE);
    lfo_acc = lfo_acc + step[31:0];
    // u = 2*x + 0.8 clamped to 0..1, then smoothstep
    u = 4 * sine + 52429;
    if (u < 0) begin
      u = 0;
    end
    if (u > 65536) begin
      u = 65536;
    end
    u2     = (u * u + 32768) >>> 16;
    shaped = (u2 * (196608 - 2 * u) + 32768) >>> 16;
    // depth saturates at full
    amt  = (depth_reg > AMT_FULL) ? AMT_FULL : longint'(depth_reg);
    amt  = (amt * 65536 + 50) / 100;
    gain = 65536 - amt + ((amt * shaped + 32768) >>> 16);
    r.left_out  = apply_gain(w.left_in, gain);
    r.right_out = apply_gain(w.right_in, gain);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 6);
    end
    return $urandom_range(20, 100);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sh000000;
      3: return 24'shFFFFFF;
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic void check_word(lsg_out_t got);
    lsg_out_t want;
    if (gated_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("unexpected word: left %0d right %0d", got.left_out, got.right_out);
      end
      return;
    end
    want = gated_q.pop_front();
    if (got.left_out !== want.left_out || got.right_out !== want.right_out) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("gated word mismatch: left exp %0d got %0d, right exp %0d got %0d",
                 want.left_out, got.left_out, want.right_out, got.right_out);
      end
    end
  endfunction

  // output side: takes each word, stalls at random
  initial begin : result_check
    int hold;
    logic next_rdy;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        check_word(out_if.data);
        hold = pick_gap();
      end else if (hold == 0 && $urandom_range(0, 39) == 0) begin
        // occasional stall while a word is still being worked on
        hold = pick_gap();
      end
      if (!rst_ni) begin
        next_rdy = 1'b0;
      end else if (hold > 0) begin
        hold--;
        next_rdy = 1'b0;
      end else begin
        next_rdy = 1'b1;
      end
      out_if.ready <= next_rdy;
    end
  end

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (gated_q.size() > 0);
  endtask

  // one word into the block; the prediction is queued at acceptance
  task automatic send_word(input sample_t left, input sample_t right, input bit flush);
    lsg_in_t w;
    lsg_out_t r;
    int gap;
    w.left_in  = left;
    w.right_in = right;
    gap = pick_gap();
    if (flush) begin
      settle();
    end else if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    predict_gate(w, r);
    gated_q.push_back(r);
  endtask

  // both registers, only while the block is idle
  task automatic write_regs(input logic [CFG_DATA_W-1:0] amt_val,
                            input logic [CFG_DATA_W-1:0] rate_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_AMOUNT;
    cfg_data_i <= amt_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RATE;
    cfg_data_i <= rate_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    depth_reg = amt_val[AMT_W-1:0];
    rate_reg  = rate_val;
  endtask

  // reset settings, sample extremes and bit patterns
  task automatic test_sample_extremes();
    send_word(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_word(24'sh800000, 24'sh7FFFFF, 1'b0);
    send_word(24'sh000000, 24'sh000000, 1'b0);
    send_word(24'shFFFFFF, 24'sh000001, 1'b0);
    send_word(24'sh000001, 24'shFFFFFF, 1'b0);
    send_word(24'sh555555, 24'shAAAAAA, 1'b0);
    send_word(24'shAAAAAA, 24'sh555555, 1'b0);
  endtask

  // full depth at the top rate, then zero depth which must pass audio unchanged
  task automatic test_depth_limits();
    settle();
    write_regs(8'd100, 8'd160);
    send_word(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_word(24'sh003039, 24'shFF2BCF, 1'b0);
    send_word(24'sh800000, 24'shFFFFFF, 1'b0);
    settle();
    write_regs(8'd0, 8'd10);
    send_word(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_word(24'shFFFFFF, 24'sh000001, 1'b0);
    send_word(24'sh400000, 24'shC00000, 1'b0);
  endtask

  // depth above full saturates; rate zero freezes the lfo, rate 255 beyond range
  task automatic test_overrange_regs();
    settle();
    write_regs(8'hFF, 8'd0);
    send_word(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_word(24'sh123456, 24'shEDCBA9, 1'b0);
    send_word(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    settle();
    write_regs(8'd101, 8'd255);
    send_word(24'sh800000, 24'sh7FFFFF, 1'b0);
    send_word(24'sh000001, 24'shFFFFFF, 1'b0);
    send_word(24'sh2AAAAA, 24'shD55555, 1'b0);
  endtask

  // long run at the fastest rate: rising sine, upper clamp, over the top
  task automatic test_lfo_sweep();
    settle();
    write_regs(8'd100, 8'd255);
    calm = 1'b1;
    for (int n = 0; n < SWEEP_WORDS; n++) begin
      send_word(pick_sample(), pick_sample(), 1'b0);
    end
    calm = 1'b0;
  endtask

  // phases of random settings and samples, idling on both sides
  task automatic test_random_mix();
    logic [CFG_DATA_W-1:0] amt_val;
    logic [CFG_DATA_W-1:0] rate_val;
    int per_phase;
    per_phase = RANDOM_WORDS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0: amt_val = $urandom_range(0, 100);
        1: amt_val = 8'd100;
        2: amt_val = $urandom_range(101, 255);
        default: amt_val = 8'd0;
      endcase
      case ($urandom_range(0, 3))
        0: rate_val = $urandom_range(10, 160);
        1: rate_val = 8'd160;
        2: rate_val = 8'd10;
        default: rate_val = $urandom_range(0, 255);
      endcase
      write_regs(amt_val, rate_val);
      // one phase runs back to back with no idling at all
      calm = (ph == 2);
      for (int n = 0; n < per_phase; n++) begin
        // sender holds off until the block has drained, forced once
        send_word(pick_sample(), pick_sample(),
                  (ph == 1 && n == per_phase / 2) || $urandom_range(0, 99) == 0);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_AMOUNT;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    build_sine_rom();
    lfo_acc   = '0;
    depth_reg = AMT_RESET;
    rate_reg  = RATE_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_extremes();
    test_depth_limits();
    test_overrange_regs();
    test_lfo_sweep();
    test_random_mix();

    // everything back, then a quiet tail to catch stray words
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
